// File: src/led_pkg.sv
// Shared types and constants for the edit distance core.
`timescale 1ns / 1ps

package led_pkg;

    // Item kinds
    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_SECOND  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam int unsigned DIST_W = 7;
    localparam logic [DIST_W-1:0] TOO_LONG_DIST = 7'd99;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
    } led_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } led_out_t;

endpackage

// File: src/levenshtein_edit_distance_core.sv
// Load items are taken while the FSM is idle, one load item per cycle sustained
// while no compute runs. A compute item walks the DP cells one cell per cycle in
// S_CELL, with an S_ROW fetch before each row, using the DP row memory's read and
// write ports. Empty or over-long words skip the DP and go straight to S_DONE.
// Reset (aresetn low, synchronous) clears both word lengths, the FSM and the
// output valid; word and row memories hold no reset and need no clearing pass.
`timescale 1ns / 1ps

module levenshtein_edit_distance_core #(
    parameter int unsigned WORD_SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  led_pkg::led_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output led_pkg::led_out_t m_data
);
    import led_pkg::*;

    localparam int unsigned LW    = $clog2(WORD_SLOTS + 1);
    localparam int unsigned DW    = $clog2(WORD_SLOTS);
    localparam int unsigned DEPTH = WORD_SLOTS - 1;
    localparam int unsigned AW    = (WORD_SLOTS > 2) ? $clog2(WORD_SLOTS - 1) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_CELL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [LW-1:0] first_len_reg, first_len_next;
    logic [LW-1:0] second_len_reg, second_len_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] left_reg, left_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic              res_long_reg, res_long_next;
    logic              m_valid_reg, m_valid_next;
    led_out_t          out_reg, out_next;

    // Memories and their ports
    logic [7:0]    first_mem [DEPTH];
    logic [7:0]    second_mem [DEPTH];
    logic [DW-1:0] row_mem [DEPTH];

    logic          fw_wr_en, sw_wr_en;
    logic [AW-1:0] word_wr_addr;
    logic          fw_rd_en, sw_rd_en, dp_rd_en, dp_wr_en;
    logic [AW-1:0] fw_rd_addr, sw_rd_addr, dp_rd_addr, dp_wr_addr;
    logic [DW-1:0] dp_wr_data;
    logic [7:0]    fw_rd_data_reg, sw_rd_data_reg;
    logic [DW-1:0] dp_rd_data_reg;

    logic          accept;
    logic [LW-1:0] i_m1, j_m1, len_sel;
    logic [LW-1:0] above, cost, up1, left1, diag1, min_ul, cell_val;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign i_m1 = i_reg - LW'(1);
    assign j_m1 = j_reg - LW'(1);

    // One DP cell: min of above+1, left+1, diag+cost; row one reads above as j
    assign above  = (i_reg == LW'(1)) ? j_reg : LW'(dp_rd_data_reg);
    assign cost   = LW'(fw_rd_data_reg != sw_rd_data_reg);
    assign up1    = above + LW'(1);
    assign left1  = left_reg + LW'(1);
    assign diag1  = diag_reg + cost;
    assign min_ul = (up1 < left1) ? up1 : left1;
    assign cell_val = (min_ul < diag1) ? min_ul : diag1;

    assign len_sel = (s_data.kind == KIND_FIRST) ? first_len_reg : second_len_reg;
    assign word_wr_addr = len_sel[AW-1:0];

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        diag_next       = diag_reg;
        left_next       = left_reg;
        res_dist_next   = res_dist_reg;
        res_long_next   = res_long_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        fw_wr_en        = 1'b0;
        sw_wr_en        = 1'b0;
        fw_rd_en        = 1'b0;
        sw_rd_en        = 1'b0;
        dp_rd_en        = 1'b0;
        dp_wr_en        = 1'b0;
        fw_rd_addr      = i_m1[AW-1:0];
        sw_rd_addr      = j_reg[AW-1:0];
        dp_rd_addr      = j_reg[AW-1:0];
        dp_wr_addr      = j_m1[AW-1:0];
        dp_wr_data      = cell_val[DW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (s_data.kind)
                        KIND_FIRST: begin
                            fw_wr_en = (first_len_reg < LW'(WORD_SLOTS - 1));
                            if (first_len_reg < LW'(WORD_SLOTS)) begin
                                first_len_next = first_len_reg + LW'(1);
                            end
                        end
                        KIND_SECOND: begin
                            sw_wr_en = (second_len_reg < LW'(WORD_SLOTS - 1));
                            if (second_len_reg < LW'(WORD_SLOTS)) begin
                                second_len_next = second_len_reg + LW'(1);
                            end
                        end
                        KIND_COMPUTE: begin
                            res_long_next = 1'b0;
                            priority if (first_len_reg == LW'(WORD_SLOTS) ||
                                         second_len_reg == LW'(WORD_SLOTS)) begin
                                res_dist_next = TOO_LONG_DIST;
                                res_long_next = 1'b1;
                                state_next    = S_DONE;
                            end else if (first_len_reg == '0) begin
                                res_dist_next = DIST_W'(second_len_reg);
                                state_next    = S_DONE;
                            end else if (second_len_reg == '0) begin
                                res_dist_next = DIST_W'(first_len_reg);
                                state_next    = S_DONE;
                            end else begin
                                i_next     = LW'(1);
                                state_next = S_ROW;
                            end
                        end
                        default: begin
                            // unused kind: drop the item
                        end
                    endcase
                end
            end
            S_ROW: begin
                // Fetch the row character and the first cell's operands
                fw_rd_en   = 1'b1;
                sw_rd_en   = 1'b1;
                dp_rd_en   = 1'b1;
                sw_rd_addr = '0;
                dp_rd_addr = '0;
                j_next     = LW'(1);
                diag_next  = i_m1;
                left_next  = i_reg;
                state_next = S_CELL;
            end
            S_CELL: begin
                // Write back this cell, fetch the next one
                dp_wr_en  = 1'b1;
                left_next = cell_val;
                diag_next = above;
                if (j_reg == second_len_reg) begin
                    if (i_reg == first_len_reg) begin
                        res_dist_next = DIST_W'(cell_val);
                        state_next    = S_DONE;
                    end else begin
                        i_next     = i_reg + LW'(1);
                        state_next = S_ROW;
                    end
                end else begin
                    sw_rd_en = 1'b1;
                    dp_rd_en = 1'b1;
                    j_next   = j_reg + LW'(1);
                end
            end
            S_DONE: begin
                // Hand the result to the output register and clear the words
                if (!m_valid_reg || m_ready) begin
                    out_next.distance = res_dist_reg;
                    out_next.too_long = res_long_reg;
                    m_valid_next      = 1'b1;
                    first_len_next    = '0;
                    second_len_next   = '0;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            first_len_reg  <= '0;
            second_len_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        diag_reg     <= diag_next;
        left_reg     <= left_next;
        res_dist_reg <= res_dist_next;
        res_long_reg <= res_long_next;
        out_reg      <= out_next;
    end

    // First word memory
    always_ff @(posedge aclk) begin
        if (fw_wr_en) begin
            first_mem[word_wr_addr] <= s_data.char_code;
        end
        if (fw_rd_en) begin
            fw_rd_data_reg <= first_mem[fw_rd_addr];
        end
    end

    // Second word memory
    always_ff @(posedge aclk) begin
        if (sw_wr_en) begin
            second_mem[word_wr_addr] <= s_data.char_code;
        end
        if (sw_rd_en) begin
            sw_rd_data_reg <= second_mem[sw_rd_addr];
        end
    end

    // DP row memory; the read for cell j+1 never hits the cell j being written
    always_ff @(posedge aclk) begin
        if (dp_wr_en) begin
            row_mem[dp_wr_addr] <= dp_wr_data;
        end
        if (dp_rd_en) begin
            dp_rd_data_reg <= row_mem[dp_rd_addr];
        end
    end

endmodule

// File: src/led_checker.sv
// Port-level checks for the edit distance core, bound to the top level.
`timescale 1ns / 1ps

module led_checker #(
    parameter int unsigned WORD_SLOTS = 16
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input led_pkg::led_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input led_pkg::led_out_t m_data
);
    import led_pkg::*;

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Flag an over-long word with the fixed code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.too_long |-> m_data.distance == TOO_LONG_DIST)
        else $error("too_long result without the fixed distance");

    // Bound a normal distance by the word capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.too_long |-> m_data.distance < DIST_W'(WORD_SLOTS))
        else $error("distance out of range");

    // Stall the input right after a compute item
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == KIND_COMPUTE |=> !s_ready)
        else $error("input taken while a compute runs");

endmodule

bind levenshtein_edit_distance_core led_checker #(
    .WORD_SLOTS(WORD_SLOTS)
) u_led_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: verif/led_distance_scoreboard_pkg.sv
// Edit distance predictor and result scoreboard for the edit distance core test.
`timescale 1ns / 1ps

package led_distance_scoreboard_pkg;

    import led_pkg::*;

    localparam int unsigned WORD_SLOTS = 16;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    class led_distance_scoreboard;

        // Predictor state: index 0 is the first word, index 1 the second
        logic [7:0]  word_chars[2][WORD_SLOTS-1];
        int unsigned word_len[2];
        led_out_t    distances_due[$];
        int unsigned mismatch_count;
        int unsigned results_seen;

        function new();
            word_len[0]    = 0;
            word_len[1]    = 0;
            mismatch_count = 0;
            results_seen   = 0;
        endfunction

        function int unsigned pending();
            return distances_due.size();
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatch_count++;
        endfunction

        // Single-row Levenshtein with unit costs; 99 when either word saturated
        function led_out_t predict_distance();
            led_out_t    res;
            int unsigned row[WORD_SLOTS];
            int unsigned diag;
            int unsigned above;
            int unsigned best;
            int unsigned la;
            int unsigned lb;
            la = word_len[0];
            lb = word_len[1];
            if (la >= WORD_SLOTS || lb >= WORD_SLOTS) begin
                res.distance = TOO_LONG_DIST;
                res.too_long = 1'b1;
                return res;
            end
            for (int j = 0; j <= lb; j++) row[j] = j;
            for (int i = 1; i <= la; i++) begin
                diag   = row[0];
                row[0] = i;
                for (int j = 1; j <= lb; j++) begin
                    above = row[j];
                    best  = diag + ((word_chars[0][i-1] == word_chars[1][j-1]) ? 0 : 1);
                    if (above + 1 < best) best = above + 1;
                    if (row[j-1] + 1 < best) best = row[j-1] + 1;
                    row[j] = best;
                    diag   = above;
                end
            end
            res.distance = DIST_W'(row[lb]);
            res.too_long = 1'b0;
            return res;
        endfunction

        // Apply one accepted input item to the predictor
        function void note_item(led_in_t item);
            int w;
            case (item.kind)
                KIND_FIRST, KIND_SECOND: begin
                    w = (item.kind == KIND_FIRST) ? 0 : 1;
                    if (word_len[w] < WORD_SLOTS - 1) word_chars[w][word_len[w]] = item.char_code;
                    if (word_len[w] < WORD_SLOTS) word_len[w]++;
                end
                KIND_COMPUTE: begin
                    distances_due.push_back(predict_distance());
                    word_len[0] = 0;
                    word_len[1] = 0;
                end
                default: begin
                    // unused kind: nothing changes
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest expected distance
        function void check_result(led_out_t got);
            led_out_t want;
            results_seen++;
            if (distances_due.size() == 0) begin
                report($sformatf("unexpected result distance=%0d too_long=%0b",
                                 got.distance, got.too_long));
                return;
            end
            want = distances_due.pop_front();
            if (got.distance !== want.distance)
                report($sformatf("result %0d: distance %0d, expected %0d",
                                 results_seen, got.distance, want.distance));
            if (got.too_long !== want.too_long)
                report($sformatf("result %0d: too_long %0b, expected %0b",
                                 results_seen, got.too_long, want.too_long));
        endfunction

        function void flag_leftovers();
            if (distances_due.size() != 0)
                report($sformatf("%0d expected results never arrived", distances_due.size()));
        endfunction

    endclass

endpackage

// File: verif/levenshtein_edit_distance_core_test.sv
// Top-level test for the edit distance core: stimulus, pacing and result checks.
`timescale 1ns / 1ps

module levenshtein_edit_distance_core_test;

    import led_pkg::*;
    import led_distance_scoreboard_pkg::*;

    localparam int unsigned ITEM_TARGET  = 1650;
    localparam int unsigned DRAIN_CYCLES = 300;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    led_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    led_out_t m_data;

    led_distance_scoreboard distance_board;
    int unsigned            loads_sent;
    int unsigned            burst_left;

    levenshtein_edit_distance_core #(
        .WORD_SLOTS(WORD_SLOTS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hold valid and payload until the item is taken; called at a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [7:0] code);
        led_in_t item;
        item.kind      = kind;
        item.char_code = code;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        distance_board.note_item(item);
        @(negedge aclk);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    // Send one item, then close the burst with a random gap when it runs out
    task automatic push_item(input logic [1:0] kind, input logic [7:0] code);
        send_item(kind, code);
        if (kind != KIND_UNUSED) loads_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            idle_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_for_results();
        if (distance_board.pending() != 0) begin
            s_valid <= 1'b0;
            while (distance_board.pending() != 0) @(negedge aclk);
        end
    endtask

    function automatic logic [7:0] pick_char(input int unsigned style);
        case (style)
            0:       return 8'h61 + 8'($urandom_range(0, 3));
            1:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Load a random pair of words in random interleaving, then compute; some calls send only noise
    task automatic send_word_pair();
        int unsigned pick;
        int unsigned first_left;
        int unsigned second_left;
        int unsigned style;
        pick  = $urandom_range(0, 99);
        style = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
        if (pick < 65) begin
            first_left  = $urandom_range(0, 6);
            second_left = $urandom_range(0, 6);
        end else if (pick < 85) begin
            first_left  = $urandom_range(0, WORD_SLOTS - 1);
            second_left = $urandom_range(0, WORD_SLOTS - 1);
        end else if (pick < 93) begin
            first_left  = $urandom_range(0, WORD_SLOTS + 2);
            second_left = $urandom_range(WORD_SLOTS, WORD_SLOTS + 2);
            if ($urandom_range(0, 1) != 0) begin
                pick        = first_left;
                first_left  = second_left;
                second_left = pick;
            end
        end else begin
            // noise: a few items of any kind, compute not guaranteed
            repeat ($urandom_range(1, 6))
                push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            return;
        end
        while (first_left + second_left != 0) begin
            if ($urandom_range(0, 19) == 0)
                push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            if (second_left == 0 || (first_left != 0 && $urandom_range(0, 1) != 0)) begin
                push_item(KIND_FIRST, pick_char(style));
                first_left--;
            end else begin
                push_item(KIND_SECOND, pick_char(style));
                second_left--;
            end
        end
        push_item(KIND_COMPUTE, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: stall on a pattern whose mode is redrawn at random
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned phase;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int n = 0; n < span; n++) begin
                @(negedge aclk);
                phase = n % 7;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) != 0);
                    2:       m_ready <= (phase == 0 || phase == 3);
                    default: m_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) distance_board.check_result(m_data);
    end

    // Stimulus
    initial begin
        distance_board = new();
        loads_sent     = 0;
        burst_left     = 8;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty words, unused kind, extreme bytes, first word too long
        push_item(KIND_COMPUTE, 8'h00);
        push_item(KIND_UNUSED, 8'hFF);
        push_item(KIND_FIRST, 8'h00);
        push_item(KIND_FIRST, 8'hFF);
        push_item(KIND_SECOND, 8'hFF);
        push_item(KIND_COMPUTE, 8'hA5);
        for (int k = 0; k < WORD_SLOTS; k++)
            push_item(KIND_FIRST, (k % 2 != 0) ? 8'hFF : 8'h00);
        push_item(KIND_SECOND, 8'h41);
        push_item(KIND_COMPUTE, 8'hFF);
        wait_for_results();

        // Random word pairs
        while (loads_sent < ITEM_TARGET) begin
            send_word_pair();
            if ($urandom_range(0, 199) == 0) wait_for_results();
        end
        s_valid <= 1'b0;

        // Drain, then allow the longest compute to finish
        while (distance_board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        distance_board.flag_leftovers();
        if (distance_board.mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #6ms;
        $display("Verification failed");
        $finish;
    end

endmodule
